// File: hw/rtl/fdn_pkg.sv
// Shared types, constants and the tanh table of the four-line delay network reverb.
`timescale 1ns / 1ps

package fdn_pkg;

  // Depth of each delay line in samples; must be a power of two.
  localparam int LINE_DEPTH = 8192;
  localparam int DEPTH_W    = $clog2(LINE_DEPTH);
  localparam int LINES      = 4;
  localparam int MEM_DEPTH  = LINES * LINE_DEPTH;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int LEN_W      = 13;
  localparam int SUM_W      = DEPTH_W + LEN_W;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_LEN_A    = 3'd0;
  localparam logic [2:0] REG_LEN_B    = 3'd1;
  localparam logic [2:0] REG_LEN_C    = 3'd2;
  localparam logic [2:0] REG_LEN_D    = 3'd3;
  localparam logic [2:0] REG_FEEDBACK = 3'd4;
  localparam logic [2:0] REG_DAMPING  = 3'd5;

  // Soft limit threshold, 0.95 in Q1.23.
  localparam logic [22:0] LIMIT_T     = 23'd7969178;
  // floor(2^46 / LIMIT_T); the quotient estimate from it is at most four low.
  localparam logic [23:0] LIMIT_RECIP = 24'((64'd1 << 46) / 64'd7969178);

  // tanh(k/64) in Q.23 for k = 0..256.
  localparam int TAB_SIZE = 257;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] STEP_Q32 = 64'd4431304193;

  typedef logic [23:0] tab_t [TAB_SIZE];

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LP_MUL,
    ST_LP_UPD,
    ST_FB_MUL,
    ST_FB_ADD,
    ST_RCP_MUL,
    ST_QT_MUL,
    ST_REM,
    ST_DIV,
    ST_TAB_MUL,
    ST_TAB_ADD,
    ST_LIM_MUL,
    ST_LIM_RES,
    ST_WRITE,
    ST_DONE
  } fdn_state_t;

  // Status returned by the soft limit divider.
  typedef struct packed {
    logic        done;
    logic [25:0] quot;
  } div_rsp_t;

  // Builds the tanh table at elaboration from a Q.32 exponential series.
  function automatic tab_t build_tanh_tab();
    tab_t        tab;
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] hi;
    logic [63:0] lo;
    e = ONE_Q32;
    s = STEP_Q32 - ONE_Q32;
    for (int k = 0; k < TAB_SIZE; k++) begin
      den = e + ONE_Q32;
      num = (64'd1 << 56) + (den >> 1);
      q   = '0;
      rem = '0;
      // Long division, one quotient bit per step.
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem  = rem - den;
          q[b] = 1'b1;
        end
      end
      tab[k] = 24'((64'd1 << 23) - q);
      hi = e >> 32;
      lo = {32'd0, e[31:0]};
      e  = e + hi * s + ((lo * s) >> 32);
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = build_tanh_tab();

endpackage

// File: hw/rtl/fdn_reverb_four_line.sv
// Top level of the four-line feedback delay network reverb with a shared multiplier.
// A line whose feedback sum exceeds the soft limit threshold adds the soft limit steps to the
// transaction (reciprocal estimate, up to four correction steps, table interpolation). The
// whole sequence runs on the shared multiplier; input is ready only in the idle state, so a
// new transaction is accepted only after the previous one has finished.
// Reset restores the default registers, clears the lowpass states and write position;
// a fill count makes unwritten delay slots read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps

module fdn_reverb_four_line (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [23:0]  left_in,
  input  logic signed [23:0]  right_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  left_out,
  output logic signed [23:0]  right_out,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_data
);
  import fdn_pkg::*;

  fdn_state_t state;
  fdn_state_t state_next;

  // Configuration registers.
  logic [LEN_W-1:0] line_len [LINES];
  logic [15:0]      feedback_gain;
  logic [16:0]      damping_coef;

  // Sequencer and delay line bookkeeping.
  logic [1:0]         ln;
  logic [DEPTH_W-1:0] wp;
  logic [DEPTH_W:0]   fill;

  // Datapath registers.
  logic signed [23:0] mono;
  logic signed [23:0] lp [LINES];
  logic signed [23:0] mem_q;
  logic               rd_valid;
  logic signed [51:0] prod;
  logic signed [25:0] w;
  logic [25:0]        q_est;
  logic [23:0]        tab_a;
  logic [23:0]        tanh_t;

  // Delay memory.
  logic [23:0] delay_mem [MEM_DEPTH];

  // Combinational datapath signals.
  logic [SUM_W-1:0]   rd_wide;
  logic [DEPTH_W-1:0] rd_addr;
  logic               rd_ok;
  logic [MEM_AW-1:0]  mem_addr;
  logic               mem_we;
  logic signed [23:0] d_eff;
  logic signed [26:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [25:0] m_sum;
  logic signed [25:0] m_val;
  logic signed [36:0] lp_sum;
  logic signed [25:0] w_calc;
  logic [25:0]        w_mag;
  logic [25:0]        w_abs;
  logic [48:0]        rem_full;
  logic               over;
  logic [8:0]         idx_a;
  logic [8:0]         idx_b;
  logic [23:0]        tab_a_c;
  logic [23:0]        tab_b_c;
  logic signed [24:0] tab_diff;
  logic signed [23:0] lim_r;
  logic               div_start;
  logic               out_load;
  div_rsp_t           div_rsp;

  function automatic logic signed [23:0] sat24(input logic signed [36:0] v);
    logic signed [23:0] r;
    if (v > 37'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -37'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = 24'(v);
    end
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_len[0]   <= 13'd1499;
      line_len[1]   <= 13'd1889;
      line_len[2]   <= 13'd2381;
      line_len[3]   <= 13'd2999;
      feedback_gain <= 16'd45875;
      damping_coef  <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEN_A:    line_len[0]   <= cfg_data[LEN_W-1:0];
        REG_LEN_B:    line_len[1]   <= cfg_data[LEN_W-1:0];
        REG_LEN_C:    line_len[2]   <= cfg_data[LEN_W-1:0];
        REG_LEN_D:    line_len[3]   <= cfg_data[LEN_W-1:0];
        REG_FEEDBACK: feedback_gain <= cfg_data[15:0];
        REG_DAMPING:  damping_coef  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read slot of the current line and whether it has been written yet.
  assign rd_wide  = SUM_W'(wp) - SUM_W'(line_len[ln]);
  assign rd_addr  = rd_wide[DEPTH_W-1:0];
  assign rd_ok    = fill[DEPTH_W] || ({1'b0, rd_addr} < fill);
  assign mem_addr = {ln, (state == ST_WRITE) ? wp : rd_addr};

  // Delay memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      delay_mem[mem_addr] <= w[23:0];
    end
    mem_q <= delay_mem[mem_addr];
  end

  assign d_eff = rd_valid ? mem_q : 24'sd0;

  // Hadamard row of the current line, halved.
  always_comb begin
    case (ln)
      2'd0: m_sum = 26'(lp[0]) + 26'(lp[1]) + 26'(lp[2]) + 26'(lp[3]);
      2'd1: m_sum = 26'(lp[0]) - 26'(lp[1]) + 26'(lp[2]) - 26'(lp[3]);
      2'd2: m_sum = 26'(lp[0]) + 26'(lp[1]) - 26'(lp[2]) - 26'(lp[3]);
      2'd3: m_sum = 26'(lp[0]) - 26'(lp[1]) - 26'(lp[2]) + 26'(lp[3]);
      default: m_sum = '0;
    endcase
  end
  assign m_val = m_sum >>> 1;

  // Table lookups for the interpolation.
  assign idx_a    = {1'b0, div_rsp.quot[24:17]};
  assign idx_b    = idx_a + 9'd1;
  assign tab_a_c  = TANH_TAB[idx_a];
  assign tab_b_c  = TANH_TAB[idx_b];
  assign tab_diff = $signed({1'b0, tab_b_c}) - $signed({1'b0, tab_a_c});

  // Operand selection of the shared multiplier.
  always_comb begin
    case (state)
      ST_LP_MUL: begin
        mul_a = 27'(d_eff) - 27'(lp[ln]);
        mul_b = $signed({8'd0, damping_coef});
      end
      ST_FB_MUL: begin
        mul_a = 27'(m_val);
        mul_b = $signed({9'd0, feedback_gain});
      end
      ST_RCP_MUL: begin
        mul_a = $signed({1'b0, w_abs});
        mul_b = $signed({1'b0, LIMIT_RECIP});
      end
      ST_QT_MUL: begin
        mul_a = $signed({1'b0, prod[48:23]});
        mul_b = $signed({2'd0, LIMIT_T});
      end
      ST_TAB_MUL: begin
        mul_a = 27'(tab_diff);
        mul_b = $signed({8'd0, div_rsp.quot[16:0]});
      end
      ST_LIM_MUL: begin
        mul_a = $signed({4'd0, LIMIT_T});
        mul_b = $signed({1'b0, tanh_t});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Lowpass update, feedback sum and soft limit result.
  assign lp_sum   = 37'(lp[ln]) + 37'(prod >>> 16);
  assign w_calc   = 26'(mono) + 26'(prod >>> 16);
  assign w_mag    = w_calc[25] ? 26'(-w_calc) : 26'(w_calc);
  assign over     = w_mag > 26'(LIMIT_T);
  assign w_abs    = w[25] ? 26'(-w) : 26'(w);
  assign rem_full = {w_abs, 23'd0} - prod[48:0];
  assign lim_r    = 24'(prod >>> 23);

  fdn_lim_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .quot_in (q_est),
    .rem_in  (rem_full[25:0]),
    .rsp     (div_rsp)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_READ;
      ST_READ:    state_next = ST_LP_MUL;
      ST_LP_MUL:  state_next = ST_LP_UPD;
      ST_LP_UPD:  state_next = (ln == 2'd3) ? ST_FB_MUL : ST_READ;
      ST_FB_MUL:  state_next = ST_FB_ADD;
      ST_FB_ADD:  state_next = over ? ST_RCP_MUL : ST_WRITE;
      ST_RCP_MUL: state_next = ST_QT_MUL;
      ST_QT_MUL:  state_next = ST_REM;
      ST_REM:     state_next = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = div_rsp.quot[25] ? ST_LIM_MUL : ST_TAB_MUL;
        end
      end
      ST_TAB_MUL: state_next = ST_TAB_ADD;
      ST_TAB_ADD: state_next = ST_LIM_MUL;
      ST_LIM_MUL: state_next = ST_LIM_RES;
      ST_LIM_RES: state_next = ST_WRITE;
      ST_WRITE:   state_next = (ln == 2'd3) ? ST_DONE : ST_FB_MUL;
      ST_DONE:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:   in_ready  = 1'b1;
      ST_REM:    div_start = 1'b1;
      ST_WRITE:  mem_we    = 1'b1;
      ST_DONE:   out_load  = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Control registers: line counter, write position and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      ln   <= '0;
      wp   <= '0;
      fill <= '0;
    end else begin
      case (state)
        ST_IDLE:   ln <= '0;
        ST_LP_UPD: ln <= ln + 2'd1;
        ST_WRITE: begin
          ln <= ln + 2'd1;
          if (ln == 2'd3) begin
            wp <= wp + 1'b1;
            if (!fill[DEPTH_W]) begin
              fill <= fill + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Lowpass states.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        lp[i] <= '0;
      end
    end else if (state == ST_LP_UPD) begin
      lp[ln] <= sat24(lp_sum);
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mono <= 24'((25'(left_in) + 25'(right_in)) >>> 1);
        end
      end
      ST_READ:    rd_valid <= rd_ok;
      ST_FB_ADD:  w <= w_calc;
      ST_QT_MUL:  q_est <= prod[48:23];
      ST_DIV: begin
        if (div_rsp.done && div_rsp.quot[25]) begin
          tanh_t <= TANH_TAB[TAB_SIZE-1];
        end
      end
      ST_TAB_MUL: tab_a <= tab_a_c;
      ST_TAB_ADD: tanh_t <= 24'(26'($signed({1'b0, tab_a})) + 26'(prod >>> 17));
      ST_LIM_RES: w <= w[25] ? -26'(lim_r) : 26'(lim_r);
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= 24'((25'(lp[0]) + 25'(lp[2])) >>> 1);
      right_out <= 24'((25'(lp[1]) + 25'(lp[3])) >>> 1);
    end
  end

  // The fill count never passes the line depth.
  assert property (@(posedge clk) disable iff (rst)
    fill <= (DEPTH_W + 1)'(LINE_DEPTH))
    else $error("fill count beyond line depth");
  // An accepted transaction starts with a read of line zero.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_READ && ln == 2'd0))
    else $error("transaction did not start at line zero");
  // Divider results only arrive while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (rst) div_rsp.done |-> state == ST_DIV)
    else $error("divider result outside the wait state");
  // The write position moves only after the last line is written.
  assert property (@(posedge clk) disable iff (rst)
    (wp != $past(wp)) |-> ($past(state) == ST_WRITE && $past(ln) == 2'd3))
    else $error("write position moved early");

endmodule

// File: hw/rtl/fdn_lim_div.sv
// Quotient correction of the soft limit scaling by 2^23 / LIMIT_T, by compare and subtract.
`timescale 1ns / 1ps

module fdn_lim_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [25:0]          quot_in,
  input  logic [25:0]          rem_in,
  output fdn_pkg::div_rsp_t    rsp
);
  import fdn_pkg::*;

  logic              busy;
  logic              done;
  logic [25:0]       rem;
  logic [25:0]       quot;

  // The estimate from the reciprocal is at most four low, so the remainder
  // starts below five thresholds; each step removes one threshold.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= rem_in;
        quot <= quot_in;
      end else if (busy) begin
        if (rem >= 26'(LIMIT_T)) begin
          rem  <= rem - 26'(LIMIT_T);
          quot <= quot + 26'd1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  // A new division only starts when the unit is free.
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  // Completion always follows a running division.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");
  // The remainder stays below five thresholds.
  assert property (@(posedge clk) disable iff (rst) busy |-> rem < 26'(5 * LIMIT_T))
    else $error("divider remainder out of range");

endmodule
